[hw/rtl/rbd_pkg.sv]
// Package for the ring buffer deque: payload types, action and status codes.
// No dependencies; rbd_if and ring_buffer_deque import it.
`default_nettype none

package rbd_pkg;

    // Payload field widths
    localparam int ActionW = 3;
    localparam int WordW   = 32;
    localparam int StatusW = 2;
    localparam int CountW  = 11;

    typedef logic        [ActionW-1:0] t_action;
    typedef logic signed [WordW-1:0]   t_word;
    typedef logic        [StatusW-1:0] t_status;
    typedef logic        [CountW-1:0]  t_count;

    // Action codes; codes above ACT_QUERY act as a query
    localparam t_action ACT_PUSH_FRONT = 3'd0;
    localparam t_action ACT_PUSH_BACK  = 3'd1;
    localparam t_action ACT_POP_FRONT  = 3'd2;
    localparam t_action ACT_POP_BACK   = 3'd3;
    localparam t_action ACT_QUERY      = 3'd4;

    // Status codes
    localparam t_status STAT_OK    = 2'd0;
    localparam t_status STAT_EMPTY = 2'd1;
    localparam t_status STAT_FULL  = 2'd2;

    // Word reported when there is nothing to report
    localparam t_word NONE_WORD = -32'sd1;

endpackage

`default_nettype wire

[hw/rtl/rbd_if.sv]
// Valid/ready channel interfaces for the ring buffer deque: request and response.
// Depends on rbd_pkg.
`default_nettype none

interface rbd_in_if;
    import rbd_pkg::*;

    logic    valid;
    logic    ready;
    t_action action;
    t_word   push_value;

    modport source (output valid, output action, output push_value, input ready);
    modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface rbd_out_if;
    import rbd_pkg::*;

    logic    valid;
    logic    ready;
    t_word   popped_value;
    t_status status;
    t_word   front_value;
    t_word   back_value;
    t_count  entry_count;
    logic    is_empty;

    modport source (output valid, output popped_value, output status, output front_value,
                    output back_value, output entry_count, output is_empty, input ready);
    modport sink   (input valid, input popped_value, input status, input front_value,
                    input back_value, input entry_count, input is_empty, output ready);
endinterface

`default_nettype wire

[hw/rtl/rbd_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module rbd_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hw/rtl/ring_buffer_deque.sv]
// Ring buffer deque top level: circular word store with front/back pointers.
// Depends on rbd_pkg, rbd_in_if, rbd_out_if and rbd_ram.
//
// Usage:
//   i_req carries one transaction per operation: an action (push front, push
//   back, pop front, pop back, query) and a word used by pushes. o_rsp returns
//   exactly one transaction per request: popped word (-1 if none), status
//   (ok, pop on empty, push dropped on full), front and back words (-1 when
//   empty), entry count and empty flag, all as seen after the action.
// Response timing:
//   Pushes, queries, failed pops and pops that empty the queue produce their
//   response in the cycle after acceptance; one such transaction per cycle while
//   o_rsp does not stall. A pop that leaves words behind passes through ST_READ:
//   the new end word is fetched through the single read port of the store to
//   refresh the cached front or back word. No request is taken meanwhile.
// Reset:
//   Synchronous, active low. Pointers and count clear, the queue is empty.
//   The store itself is not cleared; only pushed entries are ever read.
// Back-pressure:
//   The response sits in an output register. A new request is accepted while
//   that register is empty or is being drained in the same cycle; a stalled
//   receiver holds the response and stalls i_req.
`default_nettype none

module ring_buffer_deque #(
    parameter int DEPTH = 1024
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rbd_in_if.sink      i_req,
    rbd_out_if.source   o_rsp
);
    import rbd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    // Sequencer states
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    // Pointer stepping with wrap at the store depth
    function automatic logic [AW-1:0] f_step_up(input logic [AW-1:0] idx);
        return (idx >= LAST_IDX) ? '0 : AW'(idx + 1'b1);
    endfunction

    function automatic logic [AW-1:0] f_step_down(input logic [AW-1:0] idx);
        return (idx == '0) ? LAST_IDX : AW'(idx - 1'b1);
    endfunction

    // Control state
    logic          r_state,   n_state;
    logic          r_pop_front, n_pop_front;
    logic [AW-1:0] r_head,    n_head;
    logic [AW-1:0] r_tail,    n_tail;
    logic [CW-1:0] r_count,   n_count;
    logic          r_out_valid, n_out_valid;

    // Cached end words, valid while the count is nonzero
    t_word r_front, n_front;
    t_word r_back,  n_back;

    // Response register
    t_word   r_out_popped, n_out_popped;
    t_status r_out_status, n_out_status;
    t_word   r_out_front,  n_out_front;
    t_word   r_out_back,   n_out_back;
    t_count  r_out_count,  n_out_count;
    logic    r_out_empty,  n_out_empty;

    // Store port signals
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    t_word         ram_rdata;

    logic          req_accept;
    logic [AW-1:0] step_idx;

    rbd_ram #(
        .WIDTH  (WordW),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_req.push_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Take a request only out of reset, between operations and with room in
    // the response register
    assign i_req.ready = i_rst_n && (r_state == ST_IDLE) && (!r_out_valid || o_rsp.ready);
    assign req_accept  = i_req.valid && i_req.ready;

    always_comb begin
        n_state      = r_state;
        n_pop_front  = r_pop_front;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_front      = r_front;
        n_back       = r_back;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_popped = r_out_popped;
        n_out_status = r_out_status;
        n_out_front  = r_out_front;
        n_out_back   = r_out_back;
        n_out_count  = r_out_count;
        n_out_empty  = r_out_empty;
        ram_we       = 1'b0;
        ram_waddr    = r_tail;
        ram_re       = 1'b0;
        ram_raddr    = r_head;
        step_idx     = '0;

        if (r_state == ST_READ) begin
            // Refresh the cached end word from the store and release the response
            n_state     = ST_IDLE;
            n_out_valid = 1'b1;
            if (r_pop_front) begin
                n_front     = ram_rdata;
                n_out_front = ram_rdata;
            end else begin
                n_back     = ram_rdata;
                n_out_back = ram_rdata;
            end
        end else if (req_accept) begin
            n_out_popped = NONE_WORD;
            n_out_status = STAT_OK;
            n_out_valid  = 1'b1;

            case (i_req.action)
                ACT_PUSH_FRONT: begin
                    if (r_count == FULL_CNT) begin
                        n_out_status = STAT_FULL;
                    end else begin
                        step_idx  = f_step_down(r_head);
                        ram_we    = 1'b1;
                        ram_waddr = step_idx;
                        n_head    = step_idx;
                        n_count   = CW'(r_count + 1'b1);
                        n_front   = i_req.push_value;
                        if (r_count == '0) begin
                            n_back = i_req.push_value;
                        end
                    end
                end
                ACT_PUSH_BACK: begin
                    if (r_count == FULL_CNT) begin
                        n_out_status = STAT_FULL;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_tail;
                        n_tail    = f_step_up(r_tail);
                        n_count   = CW'(r_count + 1'b1);
                        n_back    = i_req.push_value;
                        if (r_count == '0) begin
                            n_front = i_req.push_value;
                        end
                    end
                end
                ACT_POP_FRONT: begin
                    if (r_count == '0) begin
                        n_out_status = STAT_EMPTY;
                    end else begin
                        n_out_popped = r_front;
                        step_idx     = f_step_up(r_head);
                        n_head       = step_idx;
                        n_count      = CW'(r_count - 1'b1);
                        if (r_count > CW'(1)) begin
                            // Fetch the new front word; hold the response back through ST_READ
                            ram_re      = 1'b1;
                            ram_raddr   = step_idx;
                            n_state     = ST_READ;
                            n_pop_front = 1'b1;
                            n_out_valid = 1'b0;
                        end
                    end
                end
                ACT_POP_BACK: begin
                    if (r_count == '0) begin
                        n_out_status = STAT_EMPTY;
                    end else begin
                        n_out_popped = r_back;
                        step_idx     = f_step_down(r_tail);
                        n_tail       = step_idx;
                        n_count      = CW'(r_count - 1'b1);
                        if (r_count > CW'(1)) begin
                            // Fetch the new back word, one slot below the new tail
                            ram_re      = 1'b1;
                            ram_raddr   = f_step_down(step_idx);
                            n_state     = ST_READ;
                            n_pop_front = 1'b0;
                            n_out_valid = 1'b0;
                        end
                    end
                end
                default: begin
                    // Query and unused codes: report only
                end
            endcase

            n_out_count = CountW'(n_count);
            n_out_empty = (n_count == '0);
            n_out_front = (n_count == '0) ? NONE_WORD : n_front;
            n_out_back  = (n_count == '0) ? NONE_WORD : n_back;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pop_front <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pop_front <= n_pop_front;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front      <= n_front;
        r_back       <= n_back;
        r_out_popped <= n_out_popped;
        r_out_status <= n_out_status;
        r_out_front  <= n_out_front;
        r_out_back   <= n_out_back;
        r_out_count  <= n_out_count;
        r_out_empty  <= n_out_empty;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.popped_value = r_out_popped;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.front_value  = r_out_front;
    assign o_rsp.back_value   = r_out_back;
    assign o_rsp.entry_count  = r_out_count;
    assign o_rsp.is_empty     = r_out_empty;

endmodule

`default_nettype wire
